FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/tcpopt_pkg.sv
// constants, option codes and inter-module types for the tcp option parser
// no dependencies
package tcpopt_pkg;
   localparam int BUFFER_BYTES    = 2048;
   localparam int MAX_OPTIONS     = 5;
   localparam int FIXED_HEADER    = 20;
   localparam int MIN_DATA_OFFSET = 5;
   localparam int WORD_BYTES      = 4;
   localparam int DOFF_BYTE       = 12;

   localparam int ADDR_W    = $clog2(BUFFER_BYTES);
   localparam int LEN_W     = $clog2(BUFFER_BYTES + 1);
   localparam int OFF_W     = 16;
   localparam int LEFT_W    = 12;
   localparam int OPT_CNT_W = $clog2(MAX_OPTIONS + 1);
   localparam int IDX_W     = 4;

   localparam logic [7:0] OPT_END     = 8'd0;
   localparam logic [7:0] OPT_NOP     = 8'd1;
   localparam logic [7:0] OPT_MSS     = 8'd2;
   localparam logic [7:0] OPT_WSCALE  = 8'd3;
   localparam logic [7:0] OPT_SACK_OK = 8'd4;
   localparam logic [7:0] OPT_SACK    = 8'd5;
   localparam logic [7:0] OPT_TSTAMP  = 8'd8;

   typedef struct packed {
      logic             job_valid;
      logic [LEN_W-1:0] len;
   } front_stat_type;

   typedef struct packed {
      logic              pop;
      logic [ADDR_W-1:0] rd_addr;
   } back_ctl_type;

   // fixed part of a known option, in bytes
   function automatic logic [IDX_W-1:0] need_len(input logic [7:0] kind);
      logic [IDX_W-1:0] n;
      case (kind)
         OPT_MSS:    n = IDX_W'(4);
         OPT_WSCALE: n = IDX_W'(3);
         OPT_TSTAMP: n = IDX_W'(10);
         default:    n = IDX_W'(2);
      endcase
      return n;
   endfunction
endpackage

FILE: rtl/tcpopt_front.sv
// front end: byte store, byte counter and packet job queue
// depends on tcpopt_pkg
module tcpopt_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   req_packet_byte,
   input  logic                         req_last_byte,
   input  tcpopt_pkg::back_ctl_type     back_ctl,
   output tcpopt_pkg::front_stat_type   front_stat,
   output logic [7:0]                   rd_data
);
   import tcpopt_pkg::*;

   logic [7:0]       mem [BUFFER_BYTES];
   logic [7:0]       rd_data_ff;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] q_len_ff [2];
   logic             q_wr_ff, q_rd_ff;
   logic [1:0]       q_cnt_ff, q_cnt_in;
   logic             room;
   logic             push;
   logic [LEN_W-1:0] push_len;

   assign room     = cnt_ff < LEN_W'(BUFFER_BYTES);
   assign push     = accept && req_last_byte;
   assign push_len = room ? cnt_ff + LEN_W'(1) : cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = req_last_byte ? '0 : push_len;
      end
      q_cnt_in = q_cnt_ff + 2'(push) - 2'(back_ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         q_cnt_ff <= q_cnt_in;
         if (push) q_wr_ff <= ~q_wr_ff;
         if (back_ctl.pop) q_rd_ff <= ~q_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_len_ff[q_wr_ff] <= push_len;
      if (accept && room) mem[cnt_ff[ADDR_W-1:0]] <= req_packet_byte;
      rd_data_ff <= mem[back_ctl.rd_addr];
   end

   assign rd_data              = rd_data_ff;
   assign front_stat.job_valid = q_cnt_ff != 2'd0;
   assign front_stat.len       = q_len_ff[q_rd_ff];
endmodule

FILE: rtl/tcpopt_back.sv
// back end: option walker, one store byte per cycle, and result register
// depends on tcpopt_pkg
module tcpopt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  tcpopt_pkg::front_stat_type  front_stat,
   input  logic [7:0]                  rd_data,
   output tcpopt_pkg::back_ctl_type    back_ctl,
   output logic                        active,
   output logic                        rsp_valid,
   output logic                        rsp_parse_status,
   output logic [15:0]                 rsp_max_segment_size,
   output logic [7:0]                  rsp_window_scale,
   output logic [31:0]                 rsp_timestamp_value,
   output logic [31:0]                 rsp_timestamp_echo,
   output logic signed [11:0]          rsp_options_left
);
   import tcpopt_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DOFF     = 3'd1;
   localparam logic [2:0] S_TYPE     = 3'd2;
   localparam logic [2:0] S_TYPE_DAT = 3'd3;
   localparam logic [2:0] S_FLD      = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [OFF_W-1:0]         off_ff, off_in;
   logic signed [LEFT_W-1:0] left_ff, left_in;
   logic [OPT_CNT_W-1:0]     ocnt_ff, ocnt_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [7:0]               kind_ff, kind_in;
   logic [7:0]               olen_ff, olen_in;
   logic [15:0]              mss_ff, mss_in;
   logic [7:0]               ws_ff, ws_in;
   logic [31:0]              tsv_ff, tsv_in;
   logic [31:0]              tse_ff, tse_in;
   logic                     fin_ok, fin_err;
   logic [OFF_W-1:0]         len_w;
   logic [3:0]               doff;
   logic [5:0]               hdr_opt;
   logic                     rsp_valid_ff;
   logic                     rsp_status_ff;
   logic [15:0]              rsp_mss_ff;
   logic [7:0]               rsp_ws_ff;
   logic [31:0]              rsp_tsv_ff, rsp_tse_ff;
   logic signed [11:0]       rsp_left_ff;

   assign len_w   = OFF_W'(len_ff);
   assign doff    = rd_data[7:4];
   assign hdr_opt = 6'(doff - 4'(MIN_DATA_OFFSET)) * 6'(WORD_BYTES);

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      off_in   = off_ff;
      left_in  = left_ff;
      ocnt_in  = ocnt_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      olen_in  = olen_ff;
      mss_in   = mss_ff;
      ws_in    = ws_ff;
      tsv_in   = tsv_ff;
      tse_in   = tse_ff;
      fin_ok   = 1'b0;
      fin_err  = 1'b0;
      back_ctl.pop     = 1'b0;
      back_ctl.rd_addr = ADDR_W'(DOFF_BYTE);
      case (state_ff)
         S_IDLE: begin
            if (front_stat.job_valid) begin
               back_ctl.pop = 1'b1;
               len_in       = front_stat.len;
               if (front_stat.len < LEN_W'(FIXED_HEADER)) begin
                  fin_err = 1'b1;
               end else begin
                  state_in = S_DOFF;
               end
            end
         end
         S_DOFF: begin
            mss_in  = '0;
            ws_in   = '0;
            tsv_in  = '0;
            tse_in  = '0;
            off_in  = OFF_W'(FIXED_HEADER);
            ocnt_in = '0;
            left_in = LEFT_W'(hdr_opt);
            if (doff < 4'(MIN_DATA_OFFSET) ||
                OFF_W'(FIXED_HEADER) + OFF_W'(hdr_opt) > len_w) begin
               fin_err  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_TYPE;
            end
         end
         S_TYPE: begin
            back_ctl.rd_addr = off_ff[ADDR_W-1:0];
            if (ocnt_ff == OPT_CNT_W'(MAX_OPTIONS) || off_ff >= len_w) begin
               fin_ok   = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_TYPE_DAT;
            end
         end
         S_TYPE_DAT: begin
            back_ctl.rd_addr = ADDR_W'(off_ff + OFF_W'(1));
            case (rd_data)
               OPT_END, OPT_NOP: begin
                  off_in  = off_ff + OFF_W'(1);
                  left_in = left_ff - LEFT_W'(1);
                  if (rd_data == OPT_END || left_in <= LEFT_W'(0)) begin
                     fin_ok   = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     ocnt_in  = ocnt_ff + OPT_CNT_W'(1);
                     state_in = S_TYPE;
                  end
               end
               OPT_MSS, OPT_WSCALE, OPT_SACK_OK, OPT_SACK, OPT_TSTAMP: begin
                  if (off_ff + OFF_W'(need_len(rd_data)) > len_w) begin
                     fin_err  = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     kind_in  = rd_data;
                     idx_in   = IDX_W'(1);
                     state_in = S_FLD;
                  end
               end
               default: begin
                  fin_ok   = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FLD: begin
            // rd_data is the option byte at idx; fetch the next one meanwhile
            back_ctl.rd_addr = ADDR_W'(off_ff + OFF_W'(idx_ff) + OFF_W'(1));
            if (idx_ff == IDX_W'(1)) olen_in = rd_data;
            if (kind_ff == OPT_MSS && idx_ff >= IDX_W'(2)) mss_in = {mss_ff[7:0], rd_data};
            if (kind_ff == OPT_WSCALE && idx_ff == IDX_W'(2)) ws_in = rd_data;
            if (kind_ff == OPT_TSTAMP && idx_ff >= IDX_W'(2) && idx_ff <= IDX_W'(5))
               tsv_in = {tsv_ff[23:0], rd_data};
            if (kind_ff == OPT_TSTAMP && idx_ff >= IDX_W'(6))
               tse_in = {tse_ff[23:0], rd_data};
            if (idx_ff == need_len(kind_ff) - IDX_W'(1)) begin
               off_in  = off_ff + OFF_W'(olen_in);
               left_in = left_ff - LEFT_W'(olen_in);
               if (left_in <= LEFT_W'(0)) begin
                  fin_ok   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ocnt_in  = ocnt_ff + OPT_CNT_W'(1);
                  state_in = S_TYPE;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin_ok || fin_err;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      off_ff  <= off_in;
      left_ff <= left_in;
      ocnt_ff <= ocnt_in;
      idx_ff  <= idx_in;
      kind_ff <= kind_in;
      olen_ff <= olen_in;
      mss_ff  <= mss_in;
      ws_ff   <= ws_in;
      tsv_ff  <= tsv_in;
      tse_ff  <= tse_in;
      if (fin_err) begin
         rsp_status_ff <= 1'b1;
         rsp_mss_ff    <= '0;
         rsp_ws_ff     <= '0;
         rsp_tsv_ff    <= '0;
         rsp_tse_ff    <= '0;
         rsp_left_ff   <= '0;
      end else if (fin_ok) begin
         rsp_status_ff <= 1'b0;
         rsp_mss_ff    <= mss_in;
         rsp_ws_ff     <= ws_in;
         rsp_tsv_ff    <= tsv_in;
         rsp_tse_ff    <= tse_in;
         rsp_left_ff   <= 12'(left_in);
      end
   end

   assign active               = state_ff != S_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_parse_status     = rsp_status_ff;
   assign rsp_max_segment_size = rsp_mss_ff;
   assign rsp_window_scale     = rsp_ws_ff;
   assign rsp_timestamp_value  = rsp_tsv_ff;
   assign rsp_timestamp_echo   = rsp_tse_ff;
   assign rsp_options_left     = rsp_left_ff;
endmodule

FILE: rtl/tcp_option_parser.sv
// tcp option parser top level: front byte store feeding the option walker
// depends on tcpopt_pkg, tcpopt_front, tcpopt_back and assert_macros.svh
//
// Packet bytes are taken one per cycle from the first TCP header byte while
// start is high and busy is low. After the last byte busy rises and the
// walker reads the store one byte per cycle through its single read port:
// first the data offset, then each option (at most five), then it closes
// the walk and loads the result register. The result is shown on rsp_* for
// one cycle with rsp_valid and must be taken then; busy falls in the same
// cycle and the next packet may start.
`include "assert_macros.svh"
module tcp_option_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_packet_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   output logic               rsp_parse_status,
   output logic [15:0]        rsp_max_segment_size,
   output logic [7:0]         rsp_window_scale,
   output logic [31:0]        rsp_timestamp_value,
   output logic [31:0]        rsp_timestamp_echo,
   output logic signed [11:0] rsp_options_left
);
   import tcpopt_pkg::*;

   front_stat_type front_stat;
   back_ctl_type   back_ctl;
   logic [7:0]     rd_data;
   logic           active;
   logic           accept;

   assign busy   = front_stat.job_valid || active;
   assign accept = start && !busy;

   tcpopt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_packet_byte (req_packet_byte),
      .req_last_byte   (req_last_byte),
      .back_ctl        (back_ctl),
      .front_stat      (front_stat),
      .rd_data         (rd_data)
   );

   tcpopt_back u_back (
      .clock                (clock),
      .reset                (reset),
      .front_stat           (front_stat),
      .rd_data              (rd_data),
      .back_ctl             (back_ctl),
      .active               (active),
      .rsp_valid            (rsp_valid),
      .rsp_parse_status     (rsp_parse_status),
      .rsp_max_segment_size (rsp_max_segment_size),
      .rsp_window_scale     (rsp_window_scale),
      .rsp_timestamp_value  (rsp_timestamp_value),
      .rsp_timestamp_echo   (rsp_timestamp_echo),
      .rsp_options_left     (rsp_options_left)
   );

   `ASSERT_NEXT(a_last_sets_busy, clock, reset, accept && req_last_byte, busy, "no walk after last byte")
   `ASSERT_NEXT(a_one_result, clock, reset, rsp_valid, !rsp_valid, "back to back results")
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_parse_status, rsp_max_segment_size == 16'd0 && rsp_options_left == 12'sd0, "error result not cleared")
   `ASSERT_IMPLIES(a_pop_idle, clock, reset, back_ctl.pop, !active, "job taken while walking")
endmodule
